[hdl/vau_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// vau_pkg
// Types, codes and constants shared by the 2-D vector arithmetic unit.
// ----------------------------------------------------------------------------
package vau_pkg;

    // Default number of fraction bits of the fixed-point format.
    localparam int FRAC_BITS_DEF = 16;

    // Operation codes.
    typedef enum logic [2:0] {
        MODE_ADD   = 3'd0,
        MODE_SUB   = 3'd1,
        MODE_SCALE = 3'd2,
        MODE_LEN   = 3'd3,
        MODE_NORM  = 3'd4
    } t_mode;

    // Status codes.
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SAT  = 2'd1;
    localparam logic [1:0] ST_ZERO = 2'd2;

    // Input beat.
    typedef struct packed {
        logic [2:0]         mode;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] bx;
        logic signed [31:0] by;
        logic signed [31:0] factor;
    } t_in;

    // Output beat.
    typedef struct packed {
        logic signed [31:0] res_x;
        logic signed [31:0] res_y;
        logic [31:0]        res_len;
        logic [1:0]         status;
    } t_out;

    // Per-item data that rides along the cell chain.
    typedef struct packed {
        logic [2:0]         mode;
        logic               neg_x;
        logic               neg_y;
        logic [31:0]        mag_x;
        logic [31:0]        mag_y;
        logic signed [31:0] res_x;
        logic signed [31:0] res_y;
        logic [1:0]         status;
    } t_carry;

    // Digit-by-digit square root state.
    typedef struct packed {
        logic [63:0] rad;
        logic [33:0] rem;
        logic [31:0] root;
    } t_sq_state;

endpackage
`default_nettype wire

[hdl/vector2d_arithmetic_unit_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// vector2d_arithmetic_unit_core
// Add, subtract, scale, length and normalize on Q-format 2-D vectors.
// ----------------------------------------------------------------------------
// The unit takes one beat per clock cycle while no valid output beat is
// stalled and returns one result beat per input beat, in order. A beat
// passes stage A (multiply), stage B (sum), a chain of 32 square root
// cells (one root bit each), a chain of FRAC_BITS + 1 divider cells (one
// quotient bit each) and the output register. Every mode travels the whole
// chain; the default format is Q16.16. A stall on a valid output beat holds
// the whole chain and is passed back to the input in the same cycle.
module vector2d_arithmetic_unit_core #(
    parameter int FRAC_BITS = vau_pkg::FRAC_BITS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire vau_pkg::t_in  i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output vau_pkg::t_out      o_out_data
);

    localparam int QW     = FRAC_BITS + 1;
    localparam int NSQ    = 32;
    localparam int NDIV   = QW;

    logic en;

    // Stage A: products and add/subtract.
    logic               r_a_valid;
    logic [2:0]         r_a_mode;
    logic               r_a_neg_x;
    logic               r_a_neg_y;
    logic [31:0]        r_a_mag_x;
    logic [31:0]        r_a_mag_y;
    logic signed [63:0] r_a_px;
    logic signed [63:0] r_a_py;
    logic [63:0]        r_a_sqx;
    logic [63:0]        r_a_sqy;
    logic signed [31:0] r_a_sx;
    logic signed [31:0] r_a_sy;
    logic               r_a_ssat;

    // Stage B: sum of squares and scale results.
    logic               r_b_valid;
    vau_pkg::t_carry    r_b_carry;
    logic [63:0]        r_b_rad;

    logic [31:0]        mag_x;
    logic [31:0]        mag_y;
    logic [32:0]        sum_x;
    logic [32:0]        sum_y;
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic               ovf_x;
    logic               ovf_y;
    logic               is_sub;
    logic signed [63:0] sh_x;
    logic signed [63:0] sh_y;
    logic               sat_px;
    logic               sat_py;
    vau_pkg::t_carry    n_b_carry;

    logic               r_out_valid;
    vau_pkg::t_out      r_out;
    vau_pkg::t_out      n_out;

    // The whole chain moves unless a finished beat is held at the output.
    assign en         = !(r_out_valid && i_out_stall);
    assign o_in_stall = !en;

    // Magnitudes and saturating add/subtract from the input beat.
    always_comb begin
        mag_x  = i_in_data.ax[31] ? 32'(-i_in_data.ax) : 32'(i_in_data.ax);
        mag_y  = i_in_data.ay[31] ? 32'(-i_in_data.ay) : 32'(i_in_data.ay);
        is_sub = (i_in_data.mode == vau_pkg::MODE_SUB);
        sum_x  = is_sub ? ({i_in_data.ax[31], i_in_data.ax} - {i_in_data.bx[31], i_in_data.bx})
                        : ({i_in_data.ax[31], i_in_data.ax} + {i_in_data.bx[31], i_in_data.bx});
        sum_y  = is_sub ? ({i_in_data.ay[31], i_in_data.ay} - {i_in_data.by[31], i_in_data.by})
                        : ({i_in_data.ay[31], i_in_data.ay} + {i_in_data.by[31], i_in_data.by});
        ovf_x  = (sum_x[32] != sum_x[31]);
        ovf_y  = (sum_y[32] != sum_y[31]);
        sx     = ovf_x ? (sum_x[32] ? 32'sh80000000 : 32'sh7fffffff) : $signed(sum_x[31:0]);
        sy     = ovf_y ? (sum_y[32] ? 32'sh80000000 : 32'sh7fffffff) : $signed(sum_y[31:0]);
    end

    // Stage A control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (en) begin
            r_a_valid <= i_in_valid;
        end
    end

    // Stage A payload: four 32x32 multipliers.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_mode  <= i_in_data.mode;
            r_a_neg_x <= i_in_data.ax[31];
            r_a_neg_y <= i_in_data.ay[31];
            r_a_mag_x <= mag_x;
            r_a_mag_y <= mag_y;
            r_a_px    <= 64'(i_in_data.ax) * 64'(i_in_data.factor);
            r_a_py    <= 64'(i_in_data.ay) * 64'(i_in_data.factor);
            r_a_sqx   <= {32'd0, mag_x} * {32'd0, mag_x};
            r_a_sqy   <= {32'd0, mag_y} * {32'd0, mag_y};
            r_a_sx    <= sx;
            r_a_sy    <= sy;
            r_a_ssat  <= ovf_x || ovf_y;
        end
    end

    // Floor shift and saturation of the scale products; pick per mode.
    always_comb begin
        sh_x   = r_a_px >>> FRAC_BITS;
        sh_y   = r_a_py >>> FRAC_BITS;
        sat_px = (sh_x[63:31] != '0) && (sh_x[63:31] != '1);
        sat_py = (sh_y[63:31] != '0) && (sh_y[63:31] != '1);
        n_b_carry.mode   = r_a_mode;
        n_b_carry.neg_x  = r_a_neg_x;
        n_b_carry.neg_y  = r_a_neg_y;
        n_b_carry.mag_x  = r_a_mag_x;
        n_b_carry.mag_y  = r_a_mag_y;
        n_b_carry.res_x  = '0;
        n_b_carry.res_y  = '0;
        n_b_carry.status = vau_pkg::ST_OK;
        case (r_a_mode)
            vau_pkg::MODE_ADD, vau_pkg::MODE_SUB: begin
                n_b_carry.res_x  = r_a_sx;
                n_b_carry.res_y  = r_a_sy;
                n_b_carry.status = r_a_ssat ? vau_pkg::ST_SAT : vau_pkg::ST_OK;
            end
            vau_pkg::MODE_SCALE: begin
                n_b_carry.res_x  = sat_px ? (sh_x[63] ? 32'sh80000000 : 32'sh7fffffff)
                                          : $signed(sh_x[31:0]);
                n_b_carry.res_y  = sat_py ? (sh_y[63] ? 32'sh80000000 : 32'sh7fffffff)
                                          : $signed(sh_y[31:0]);
                n_b_carry.status = (sat_px || sat_py) ? vau_pkg::ST_SAT : vau_pkg::ST_OK;
            end
            default: begin
            end
        endcase
    end

    // Stage B control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (en) begin
            r_b_valid <= r_a_valid;
        end
    end

    // Stage B payload.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_carry <= n_b_carry;
            r_b_rad   <= r_a_sqx + r_a_sqy;
        end
    end

    // Square root chain.
    logic               sq_valid [NSQ+1];
    vau_pkg::t_sq_state sq_state [NSQ+1];
    vau_pkg::t_carry    sq_carry [NSQ+1];

    assign sq_valid[0]      = r_b_valid;
    assign sq_state[0].rad  = r_b_rad;
    assign sq_state[0].rem  = '0;
    assign sq_state[0].root = '0;
    assign sq_carry[0]      = r_b_carry;

    for (genvar g = 0; g < NSQ; g++) begin : g_sq
        vau_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (sq_valid[g]),
            .i_sq    (sq_state[g]),
            .i_carry (sq_carry[g]),
            .o_valid (sq_valid[g+1]),
            .o_sq    (sq_state[g+1]),
            .o_carry (sq_carry[g+1])
        );
    end

    // Divider chain for normalize.
    logic            dv_valid [NDIV+1];
    logic [31:0]     dv_len   [NDIV+1];
    logic [32:0]     dv_rem_x [NDIV+1];
    logic [32:0]     dv_rem_y [NDIV+1];
    logic [QW-1:0]   dv_q_x   [NDIV+1];
    logic [QW-1:0]   dv_q_y   [NDIV+1];
    vau_pkg::t_carry dv_carry [NDIV+1];

    assign dv_valid[0] = sq_valid[NSQ];
    assign dv_len[0]   = sq_state[NSQ].root;
    assign dv_rem_x[0] = {1'b0, sq_carry[NSQ].mag_x};
    assign dv_rem_y[0] = {1'b0, sq_carry[NSQ].mag_y};
    assign dv_q_x[0]   = '0;
    assign dv_q_y[0]   = '0;
    assign dv_carry[0] = sq_carry[NSQ];

    for (genvar g = 0; g < NDIV; g++) begin : g_div
        vau_div_cell #(
            .QW (QW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (dv_valid[g]),
            .i_len   (dv_len[g]),
            .i_rem_x (dv_rem_x[g]),
            .i_rem_y (dv_rem_y[g]),
            .i_q_x   (dv_q_x[g]),
            .i_q_y   (dv_q_y[g]),
            .i_carry (dv_carry[g]),
            .o_valid (dv_valid[g+1]),
            .o_len   (dv_len[g+1]),
            .o_rem_x (dv_rem_x[g+1]),
            .o_rem_y (dv_rem_y[g+1]),
            .o_q_x   (dv_q_x[g+1]),
            .o_q_y   (dv_q_y[g+1]),
            .o_carry (dv_carry[g+1])
        );
    end

    // Assemble the result beat by mode.
    always_comb begin
        n_out.res_x   = dv_carry[NDIV].res_x;
        n_out.res_y   = dv_carry[NDIV].res_y;
        n_out.res_len = '0;
        n_out.status  = dv_carry[NDIV].status;
        case (dv_carry[NDIV].mode)
            vau_pkg::MODE_LEN: begin
                n_out.res_len = dv_len[NDIV];
            end
            vau_pkg::MODE_NORM: begin
                if (dv_len[NDIV] == '0) begin
                    n_out.status = vau_pkg::ST_ZERO;
                end else begin
                    n_out.res_x = dv_carry[NDIV].neg_x ? -$signed(32'(dv_q_x[NDIV]))
                                                       : $signed(32'(dv_q_x[NDIV]));
                    n_out.res_y = dv_carry[NDIV].neg_y ? -$signed(32'(dv_q_y[NDIV]))
                                                       : $signed(32'(dv_q_y[NDIV]));
                end
            end
            default: begin
            end
        endcase
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= dv_valid[NDIV];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    // A zero-vector normalize reports no vector and no length.
    a_zero_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status == vau_pkg::ST_ZERO) |->
            (o_out_data.res_x == '0) && (o_out_data.res_y == '0) &&
            (o_out_data.res_len == '0))
        else $error("zero normalize beat carries data");

    // A length result never comes with a vector.
    a_len_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.res_len != '0) |->
            (o_out_data.res_x == '0) && (o_out_data.res_y == '0) &&
            (o_out_data.status == vau_pkg::ST_OK))
        else $error("length beat mixed with vector result");

    // Status code three is never produced.
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.status != 2'd3))
        else $error("undefined status code");

    // A held output freezes stages A and B of the chain.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_stall |=> $stable(r_a_valid) && $stable(r_b_valid))
        else $error("chain moved while output held");
`endif

endmodule
`default_nettype wire

[hdl/vau_sqrt_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// vau_sqrt_cell
// One cell of the square root chain: resolves one root bit per cell.
// ----------------------------------------------------------------------------
module vau_sqrt_cell (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire logic               i_valid,
    input  wire vau_pkg::t_sq_state i_sq,
    input  wire vau_pkg::t_carry    i_carry,
    output logic                    o_valid,
    output vau_pkg::t_sq_state      o_sq,
    output vau_pkg::t_carry         o_carry
);

    logic               r_valid;
    vau_pkg::t_sq_state r_sq;
    vau_pkg::t_carry    r_carry;
    vau_pkg::t_sq_state n_sq;
    logic [35:0]        rem2;
    logic [35:0]        trial;
    logic [35:0]        diff;
    logic               ge;

    // Bring in the next two radicand bits and try the next root bit.
    always_comb begin
        rem2      = {i_sq.rem, i_sq.rad[63:62]};
        trial     = {2'b00, i_sq.root, 2'b01};
        diff      = rem2 - trial;
        ge        = (rem2 >= trial);
        n_sq.rad  = {i_sq.rad[61:0], 2'b00};
        n_sq.rem  = ge ? diff[33:0] : rem2[33:0];
        n_sq.root = {i_sq.root[30:0], ge};
    end

    // Control bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq    <= n_sq;
            r_carry <= i_carry;
        end
    end

    assign o_valid = r_valid;
    assign o_sq    = r_sq;
    assign o_carry = r_carry;

endmodule
`default_nettype wire

[hdl/vau_div_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// vau_div_cell
// One cell of the normalize divider: one quotient bit for each coordinate.
// ----------------------------------------------------------------------------
module vau_div_cell #(
    parameter int QW = vau_pkg::FRAC_BITS_DEF + 1
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic            i_valid,
    input  wire logic [31:0]     i_len,
    input  wire logic [32:0]     i_rem_x,
    input  wire logic [32:0]     i_rem_y,
    input  wire logic [QW-1:0]   i_q_x,
    input  wire logic [QW-1:0]   i_q_y,
    input  wire vau_pkg::t_carry i_carry,
    output logic                 o_valid,
    output logic [31:0]          o_len,
    output logic [32:0]          o_rem_x,
    output logic [32:0]          o_rem_y,
    output logic [QW-1:0]        o_q_x,
    output logic [QW-1:0]        o_q_y,
    output vau_pkg::t_carry      o_carry
);

    logic            r_valid;
    logic [31:0]     r_len;
    logic [32:0]     r_rem_x;
    logic [32:0]     r_rem_y;
    logic [QW-1:0]   r_q_x;
    logic [QW-1:0]   r_q_y;
    vau_pkg::t_carry r_carry;
    logic [32:0]     len_ext;
    logic [32:0]     dx;
    logic [32:0]     dy;
    logic            ge_x;
    logic            ge_y;
    logic [32:0]     n_rem_x;
    logic [32:0]     n_rem_y;

    // Restoring step, then shift the remainder for the next bit.
    always_comb begin
        len_ext = {1'b0, i_len};
        ge_x    = (i_rem_x >= len_ext);
        ge_y    = (i_rem_y >= len_ext);
        dx      = ge_x ? (i_rem_x - len_ext) : i_rem_x;
        dy      = ge_y ? (i_rem_y - len_ext) : i_rem_y;
        n_rem_x = {dx[31:0], 1'b0};
        n_rem_y = {dy[31:0], 1'b0};
    end

    // Control bit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // Payload.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_len   <= i_len;
            r_rem_x <= n_rem_x;
            r_rem_y <= n_rem_y;
            r_q_x   <= {i_q_x[QW-2:0], ge_x};
            r_q_y   <= {i_q_y[QW-2:0], ge_y};
            r_carry <= i_carry;
        end
    end

    assign o_valid = r_valid;
    assign o_len   = r_len;
    assign o_rem_x = r_rem_x;
    assign o_rem_y = r_rem_y;
    assign o_q_x   = r_q_x;
    assign o_q_y   = r_q_y;
    assign o_carry = r_carry;

endmodule
`default_nettype wire
